>>> hw/rtl/crfs_pkg.sv
`timescale 1ns / 1ps

package crfs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_LINES  = 64;
  localparam int COLOR_BITS = 16;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 16;
  localparam int LEN_W   = 11;
  localparam int COLOR_W = 16;
  localparam int ROW_W   = $clog2(MAX_LINES + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [COLOR_W-1:0] COLOR_MASK =
    COLOR_W'(((64'd1 << COLOR_BITS) - 64'd1) & 64'hFFFF_FFFF);

  localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_BOTTOM = 2'd3;

  localparam logic signed [COORD_W-1:0] RST_BUF_LEFT   = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_BUF_TOP    = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_BUF_RIGHT  = 16'sd319;
  localparam logic signed [COORD_W-1:0] RST_BUF_BOTTOM = 16'sd31;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } sts_t;

  function automatic logic signed [COORD_W-1:0] smax(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

endpackage

>>> hw/rtl/crfs_ctrl.sv
`timescale 1ns / 1ps

module crfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_ready,
  input  crfs_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output crfs_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.prep = (state_r == ST_PREP);
    cmd.mul  = (state_r == ST_MUL);
    cmd.step = out_valid && out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = sts.empty ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/crfs_dp.sv
`timescale 1ns / 1ps

module crfs_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  crfs_pkg::cmd_t                         cmd,
  output crfs_pkg::sts_t                         sts,
  input  logic                                   cfg_we,
  input  logic [crfs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [crfs_pkg::COORD_W-1:0]           cfg_wdata,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_rect_left,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_rect_top,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_rect_right,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_rect_bottom,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_clip_left,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_clip_top,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_clip_right,
  input  logic signed [crfs_pkg::COORD_W-1:0]    in_clip_bottom,
  input  logic [crfs_pkg::COLOR_W-1:0]           in_fill_color,
  output logic [crfs_pkg::INDEX_W-1:0]           out_span_index,
  output logic [crfs_pkg::LEN_W-1:0]             out_span_length,
  output logic [crfs_pkg::COLOR_W-1:0]           out_span_color,
  output logic                                   out_span_last
);

  localparam int CW = crfs_pkg::COORD_W;
  localparam int IW = crfs_pkg::INDEX_W;
  localparam int RW = crfs_pkg::ROW_W;
  localparam int LW = crfs_pkg::LEN_W;

  logic signed [CW-1:0] buf_left_r, buf_top_r, buf_right_r, buf_bottom_r;
  logic signed [CW-1:0] l_r, t_r, r_r, b_r;
  logic [crfs_pkg::COLOR_W-1:0] color_r;
  logic [IW-1:0] width_r, rel_x_r, rel_y_r, idx_r;
  logic [LW-1:0] len_r;
  logic [RW-1:0] rows_r, row_r;
  logic          empty_r;

  logic signed [CW:0] dx, dy;
  logic [LW-1:0]      len_nxt;
  logic [RW-1:0]      rows_nxt;
  logic [2*IW-1:0]    prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_left_r   <= crfs_pkg::RST_BUF_LEFT;
      buf_top_r    <= crfs_pkg::RST_BUF_TOP;
      buf_right_r  <= crfs_pkg::RST_BUF_RIGHT;
      buf_bottom_r <= crfs_pkg::RST_BUF_BOTTOM;
    end else if (cfg_we) begin
      case (cfg_index)
        crfs_pkg::CFG_BUF_LEFT:   buf_left_r   <= cfg_wdata;
        crfs_pkg::CFG_BUF_TOP:    buf_top_r    <= cfg_wdata;
        crfs_pkg::CFG_BUF_RIGHT:  buf_right_r  <= cfg_wdata;
        crfs_pkg::CFG_BUF_BOTTOM: buf_bottom_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Intersection of rectangle, mask and buffer area
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_r <= crfs_pkg::smax(crfs_pkg::smax(in_rect_left, in_clip_left), buf_left_r);
      t_r <= crfs_pkg::smax(crfs_pkg::smax(in_rect_top, in_clip_top), buf_top_r);
      r_r <= crfs_pkg::smin(crfs_pkg::smin(in_rect_right, in_clip_right), buf_right_r);
      b_r <= crfs_pkg::smin(crfs_pkg::smin(in_rect_bottom, in_clip_bottom), buf_bottom_r);
      color_r <= in_fill_color & crfs_pkg::COLOR_MASK;
    end
  end

  assign dx = {r_r[CW-1], r_r} - {l_r[CW-1], l_r};
  assign dy = {b_r[CW-1], b_r} - {t_r[CW-1], t_r};

  always_comb begin
    if (dx >= (CW+1)'(crfs_pkg::MAX_WIDTH - 1)) len_nxt = LW'(crfs_pkg::MAX_WIDTH);
    else len_nxt = LW'(dx) + LW'(1);
    if (dy >= (CW+1)'(crfs_pkg::MAX_LINES - 1)) rows_nxt = RW'(crfs_pkg::MAX_LINES);
    else rows_nxt = RW'(dy) + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      empty_r <= (dx < 0) || (dy < 0);
      width_r <= IW'(buf_right_r - buf_left_r) + IW'(1);
      rel_x_r <= IW'(l_r - buf_left_r);
      rel_y_r <= IW'(t_r - buf_top_r);
      len_r   <= len_nxt;
      rows_r  <= rows_nxt;
    end
  end

  assign prod = rel_y_r * width_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      idx_r <= prod[IW-1:0] + rel_x_r;
      row_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + width_r;
      row_r <= row_r + RW'(1);
    end
  end

  // empty is decided during prep from the clipped corners
  always_comb begin
    sts.empty = (dx < 0) || (dy < 0);
    sts.last  = (row_r == rows_r - RW'(1));
  end

  assign out_span_index  = idx_r;
  assign out_span_length = len_r;
  assign out_span_color  = color_r;
  assign out_span_last   = sts.last && !empty_r;

endmodule

>>> hw/rtl/clipped_rect_fill_spans_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | rect and clip corners, fill_color
// out     | output    | out_valid/out_ready| span_index, span_length, span_color, span_last
// cfg     | input     | cfg_we             | cfg_index, cfg_wdata (buffer area corners)
//
// One item at a time: accept, clipping arithmetic, index multiply, then one span per
// cycle while out_ready is high (rows up to 64, set by MAX_LINES). An empty intersection
// returns to idle straight from the clipping step and emits no spans.
// Reset (rst_n low, synchronous) restores the buffer area 0,0 .. 319,31.
// out_ready low holds the current span; no new item is taken until the last span leaves.

module clipped_rect_fill_spans_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crfs_pkg::COORD_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_rect_left,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_rect_top,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_rect_right,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_rect_bottom,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_clip_left,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_clip_top,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_clip_right,
  input  logic signed [crfs_pkg::COORD_W-1:0] in_clip_bottom,
  input  logic [crfs_pkg::COLOR_W-1:0]        in_fill_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [crfs_pkg::INDEX_W-1:0]        out_span_index,
  output logic [crfs_pkg::LEN_W-1:0]          out_span_length,
  output logic [crfs_pkg::COLOR_W-1:0]        out_span_color,
  output logic                                out_span_last
);

  crfs_pkg::cmd_t cmd;
  crfs_pkg::sts_t sts;

  crfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  crfs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_rect_left    (in_rect_left),
    .in_rect_top     (in_rect_top),
    .in_rect_right   (in_rect_right),
    .in_rect_bottom  (in_rect_bottom),
    .in_clip_left    (in_clip_left),
    .in_clip_top     (in_clip_top),
    .in_clip_right   (in_clip_right),
    .in_clip_bottom  (in_clip_bottom),
    .in_fill_color   (in_fill_color),
    .out_span_index  (out_span_index),
    .out_span_length (out_span_length),
    .out_span_color  (out_span_color),
    .out_span_last   (out_span_last)
  );

  a_busy_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while spans pending");

  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_length != '0))
    else $error("zero length span");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("span before clipping done");

  a_more_spans: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_span_last) |=> out_valid)
    else $error("request ended without last span");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_span_last) |=> in_ready)
    else $error("not idle after last span");

endmodule
